// ===== rtl/nrwf_pkg.sv =====
// nrwf_pkg: shared types and constants for the nonce replay window filter
// no dependencies; imported by nrwf_window and nonce_replay_window_filter_unit
package nrwf_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned NONCE_W       = 32;
    localparam int unsigned VERDICT_W     = 2;

    // result codes for one request
    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_TOO_OLD   = 2'd1,
        VERDICT_DUPLICATE = 2'd2,
        VERDICT_AUTH_FAIL = 2'd3
    } t_verdict;

endpackage

// ===== rtl/nrwf_window.sv =====
// nrwf_window: highest-seen register, seen bitmap, replay check and update
// depends on nrwf_pkg
module nrwf_window #(
    parameter int unsigned WINDOW_BYTES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  logic [nrwf_pkg::NONCE_W-1:0]     i_nonce,
    input  logic                             i_auth_ok,
    output nrwf_pkg::t_verdict               o_verdict
);
    import nrwf_pkg::*;

    localparam int unsigned WIN_BITS = WINDOW_BYTES * BITS_PER_BYTE;
    localparam int unsigned IDX_W    = $clog2(WIN_BITS);

    logic [NONCE_W-1:0]  r_highest;
    logic [NONCE_W-1:0]  n_highest;
    logic [WIN_BITS-1:0] r_bitmap;
    logic [WIN_BITS-1:0] n_bitmap;

    logic [NONCE_W:0]    offset;   // highest minus nonce, msb is the borrow
    logic [NONCE_W:0]    jump;     // nonce minus highest
    logic                is_older;
    logic                in_window;
    logic                newer;
    logic                bit_hit;
    t_verdict            verdict;

    // distance between the request and the window head
    always_comb begin
        offset    = {1'b0, r_highest} - {1'b0, i_nonce};
        jump      = {1'b0, i_nonce} - {1'b0, r_highest};
        is_older  = ~offset[NONCE_W];
        newer     = offset[NONCE_W];
        in_window = is_older && (offset < (NONCE_W+1)'(WIN_BITS));
        bit_hit   = in_window && r_bitmap[offset[IDX_W-1:0]];
    end

    // verdict and next window state
    always_comb begin
        n_highest = r_highest;
        n_bitmap  = r_bitmap;
        if (is_older && !in_window) begin
            verdict = VERDICT_TOO_OLD;
        end else if (bit_hit) begin
            verdict = VERDICT_DUPLICATE;
        end else if (!i_auth_ok) begin
            verdict = VERDICT_AUTH_FAIL;
        end else begin
            verdict = VERDICT_ACCEPT;
            if (newer) begin
                // age the marks by the jump, or drop them all on a large jump
                if (jump >= (NONCE_W+1)'(WIN_BITS)) begin
                    n_bitmap = '0;
                end else begin
                    n_bitmap = r_bitmap << jump[IDX_W-1:0];
                end
                n_bitmap[0] = 1'b1;
                n_highest   = i_nonce;
            end else begin
                n_bitmap[offset[IDX_W-1:0]] = 1'b1;
            end
        end
    end

    assign o_verdict = verdict;

    // window state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest <= '0;
            r_bitmap  <= '0;
        end else if (i_fire) begin
            r_highest <= n_highest;
            r_bitmap  <= n_bitmap;
        end
    end

    // rejected requests leave the window alone
    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && verdict != VERDICT_ACCEPT) |=> ($stable(r_bitmap) && $stable(r_highest)))
        else $error("window changed on a rejected request");

    // a newer accepted nonce becomes the head and is marked
    a_newer_marks_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && verdict == VERDICT_ACCEPT && newer)
            |=> (r_bitmap[0] && r_highest == $past(i_nonce)))
        else $error("newer nonce not installed as head");

    // the head never moves backwards
    a_head_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> (r_highest >= $past(r_highest)))
        else $error("highest nonce decreased");

endmodule

// ===== rtl/nonce_replay_window_filter_unit.sv =====
// Path: an accepted request passes the input register, then the result register, to o_out_valid.
// Throughput: one request per cycle unless the output stalls; the window check is combinational.
// Stall on the output side reaches the input through the held input register.
// Reset (i_rst_n low, synchronous): highest nonce 0, bitmap empty, both stages empty.
// Depends on nrwf_pkg and nrwf_window.
module nonce_replay_window_filter_unit #(
    parameter int unsigned WINDOW_BYTES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [nrwf_pkg::NONCE_W-1:0]       i_nonce,
    input  logic                               i_auth_ok,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [nrwf_pkg::VERDICT_W-1:0]     o_verdict
);
    import nrwf_pkg::*;

    logic                r_in_vld;
    logic [NONCE_W-1:0]  r_nonce;
    logic                r_auth_ok;
    logic                r_out_vld;
    t_verdict            r_verdict;
    t_verdict            verdict;
    logic                advance;
    logic                in_accept;

    // handshake control
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_nonce   <= i_nonce;
            r_auth_ok <= i_auth_ok;
        end
    end

    // replay check and window update
    nrwf_window #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_nonce   (r_nonce),
        .i_auth_ok (r_auth_ok),
        .o_verdict (verdict)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_verdict <= verdict;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_verdict   = r_verdict;

    // a held request always produces a result in the next cycle once it moves
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("result lost after advance");

    // input stage only stalls while it holds a request
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled without a blocked request");

    // a held request stays put while blocked
    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> (r_in_vld && $stable(r_nonce) && $stable(r_auth_ok)))
        else $error("blocked request changed");

endmodule

// ===== tb/sv/nrwf_board_pkg.sv =====
// nrwf_board_pkg: scoreboard for the nonce replay window filter testbench
// predicts the verdict of every request from its own copy of the window state
// depends on nrwf_pkg for the verdict codes and widths
package nrwf_board_pkg;

    import nrwf_pkg::*;

    class nonce_window_board #(int unsigned WINDOW_BYTES = 16);

        localparam int unsigned WINDOW_BITS = WINDOW_BYTES * BITS_PER_BYTE;
        localparam int unsigned REPORT_LIMIT = 10;

        typedef struct {
            logic [NONCE_W-1:0] nonce;
            logic               auth_ok;
            t_verdict           verdict;
        } t_expected_verdict;

        // predicted window state
        logic [NONCE_W-1:0]     highest;
        logic [WINDOW_BITS-1:0] seen;

        t_expected_verdict verdict_q[$];
        int unsigned       requests;
        int unsigned       checked;
        int unsigned       mismatches;
        int unsigned       unexpected;
        int unsigned       reported;
        int unsigned       verdict_count[4];

        function new();
            highest    = '0;
            seen       = '0;
            requests   = 0;
            checked    = 0;
            mismatches = 0;
            unexpected = 0;
            reported   = 0;
            foreach (verdict_count[k]) verdict_count[k] = 0;
        endfunction

        // window check and update for one request
        function t_verdict judge_nonce(logic [NONCE_W-1:0] nonce, logic auth_ok);
            logic [NONCE_W:0] hi;
            logic [NONCE_W:0] nv;
            logic [NONCE_W:0] offset;
            logic [NONCE_W:0] jump;
            hi = {1'b0, highest};
            nv = {1'b0, nonce};
            offset = hi - nv;
            // too old first, then already marked, then authentication
            if (hi >= WINDOW_BITS && nv <= hi - WINDOW_BITS) begin
                return VERDICT_TOO_OLD;
            end
            if (nv <= hi && offset < WINDOW_BITS && seen[offset]) begin
                return VERDICT_DUPLICATE;
            end
            if (!auth_ok) begin
                return VERDICT_AUTH_FAIL;
            end
            if (nv > hi) begin
                // newer nonce: age the marks by the jump, or drop them all
                jump = nv - hi;
                if (jump >= WINDOW_BITS) begin
                    seen = '0;
                end else begin
                    seen = seen << jump;
                end
                highest = nonce;
                seen[0] = 1'b1;
            end else begin
                seen[offset] = 1'b1;
            end
            return VERDICT_ACCEPT;
        endfunction

        // an accepted request: queue its verdict
        function void note_request(logic [NONCE_W-1:0] nonce, logic auth_ok);
            t_expected_verdict e;
            e.nonce   = nonce;
            e.auth_ok = auth_ok;
            e.verdict = judge_nonce(nonce, auth_ok);
            verdict_count[e.verdict]++;
            requests++;
            verdict_q.push_back(e);
        endfunction

        // an accepted result: compare with the oldest prediction
        function void check_verdict(logic [VERDICT_W-1:0] got);
            t_expected_verdict e;
            if (verdict_q.size() == 0) begin
                unexpected++;
                if (reported < REPORT_LIMIT) begin
                    reported++;
                    $display("unexpected verdict %0d with no request outstanding", got);
                end
                return;
            end
            e = verdict_q.pop_front();
            checked++;
            if (got !== e.verdict) begin
                mismatches++;
                if (reported < REPORT_LIMIT) begin
                    reported++;
                    $display("verdict mismatch: nonce 0x%08h auth %0d expected %s (%0d) got %0d",
                             e.nonce, e.auth_ok, e.verdict.name(), e.verdict, got);
                end
            end
        endfunction

        function int unsigned pending();
            return verdict_q.size();
        endfunction

        function bit failed();
            return mismatches != 0 || unexpected != 0 || verdict_q.size() != 0;
        endfunction

    endclass

endpackage

// ===== tb/sv/nonce_replay_window_filter_unit_test.sv =====
// nonce_replay_window_filter_unit_test: top of the replay window filter testbench
// directed and random nonce requests with bursty sender and patterned stall
// depends on nrwf_pkg, nrwf_board_pkg and nonce_replay_window_filter_unit
module nonce_replay_window_filter_unit_test;

    import nrwf_pkg::*;
    import nrwf_board_pkg::*;

    localparam int unsigned WINDOW_BYTES    = 16;
    localparam int unsigned WINDOW_BITS     = WINDOW_BYTES * BITS_PER_BYTE;
    localparam int unsigned RANDOM_REQUESTS = 800;
    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned DRAIN_CYCLES    = 8;

    typedef nonce_window_board #(WINDOW_BYTES) t_board;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [NONCE_W-1:0]   i_nonce;
    logic                 i_auth_ok;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [VERDICT_W-1:0] o_verdict;

    t_board board = new();

    int unsigned burst_left;
    int unsigned stall_phase_left;
    int unsigned stall_mode;
    int unsigned stall_tick;
    int unsigned idle_cycles;
    int unsigned directed_count;

    nonce_replay_window_filter_unit #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_nonce    (i_nonce),
        .i_auth_ok  (i_auth_ok),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_verdict  (o_verdict)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // one request, entered at a falling edge; returns at the falling edge after accept
    task automatic send_request(input logic [NONCE_W-1:0] nonce, input logic auth_ok);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        i_in_valid <= 1'b1;
        i_nonce    <= nonce;
        i_auth_ok  <= auth_ok;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        board.note_request(nonce, auth_ok);
        burst_left--;
        @(negedge i_clk);
    endtask

    // one random request, shaped around the predicted highest nonce
    task automatic send_random_request(ref logic [NONCE_W-1:0] recent[8], ref int unsigned slot);
        int unsigned  pick;
        longint       cand;
        logic [NONCE_W-1:0] nonce;
        logic         auth_ok;
        pick = $urandom_range(0, 99);
        auth_ok = ($urandom_range(0, 9) != 0);
        if (pick < 10) begin
            // noise: any nonce, authentication failed
            nonce   = $urandom();
            auth_ok = 1'b0;
        end else if (pick < 15) begin
            // large jump ahead, clears the window
            cand  = longint'(board.highest) + longint'($urandom_range(WINDOW_BITS, 1 << 20));
            nonce = (cand > 64'hFFFF_FFFF) ? '1 : cand[NONCE_W-1:0];
        end else if (pick < 30) begin
            // replay of a recently sent nonce
            nonce = recent[$urandom_range(0, 7)];
        end else begin
            // near the top of the window, both sides of its edges
            cand = longint'(board.highest)
                 + longint'($urandom_range(0, 2 * WINDOW_BITS + 8))
                 - longint'(WINDOW_BITS + 4);
            if (cand < 0) begin
                nonce = $urandom_range(0, board.highest);
            end else if (cand > 64'hFFFF_FFFF) begin
                nonce = '1;
            end else begin
                nonce = cand[NONCE_W-1:0];
            end
        end
        recent[slot] = nonce;
        slot = (slot + 1) % 8;
        send_request(nonce, auth_ok);
    endtask

    // receiver stall: phases of no stall, light, heavy and periodic stall
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_phase_left == 0) begin
                stall_mode       = $urandom_range(0, 3);
                stall_phase_left = $urandom_range(16, 80);
            end
            stall_phase_left--;
            stall_tick++;
            case (stall_mode)
                0: begin
                    i_out_stall <= 1'b0;
                end
                1: begin
                    i_out_stall <= ($urandom_range(0, 3) == 0);
                end
                2: begin
                    i_out_stall <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_out_stall <= (stall_tick % 5 < 2);
                end
            endcase
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_verdict(o_verdict);
        end
    end

    // watchdog on cycles with work outstanding and no handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (i_in_valid || board.pending() != 0) begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles + 1 >= IDLE_LIMIT) begin
                    $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    // stimulus
    initial begin
        logic [NONCE_W-1:0] recent[8];
        int unsigned        slot;
        int unsigned        n;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_nonce          = '0;
        i_auth_ok        = 1'b0;
        burst_left       = 0;
        slot             = 0;
        foreach (recent[k]) recent[k] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fresh window: nonce zero once, then duplicates even without authentication
        send_request(0, 1'b1);
        send_request(0, 1'b1);
        send_request(0, 1'b0);
        send_request(1, 1'b0);
        send_request(1, 1'b1);
        send_request(0, 1'b1);
        // jump of one byte, then a mark inside the window
        send_request(9, 1'b1);
        send_request(3, 1'b1);
        send_request(3, 1'b0);
        // jump of exactly the window size clears it
        send_request(9 + WINDOW_BITS, 1'b1);
        send_request(9, 1'b1);
        send_request(9, 1'b0);
        // oldest slot of the window, then aged out by a jump of one
        send_request(10, 1'b1);
        send_request(10, 1'b1);
        send_request(10 + WINDOW_BITS, 1'b1);
        send_request(10, 1'b1);
        send_request(11, 1'b0);
        // jump of one less than the window keeps only the last mark
        send_request(9 + 2 * WINDOW_BITS, 1'b1);
        send_request(10 + WINDOW_BITS, 1'b1);
        send_request(9 + WINDOW_BITS, 1'b1);
        directed_count = board.requests;

        // random part
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            send_random_request(recent, slot);
        end

        // top of the nonce range
        send_request('1, 1'b1);
        send_request(32'hFFFF_FFFF - (WINDOW_BITS - 1), 1'b1);
        send_request(32'hFFFF_FFFF - WINDOW_BITS, 1'b1);
        send_request(32'hFFFF_FFFE, 1'b0);
        send_request('1, 1'b0);
        send_request(0, 1'b1);
        directed_count += 6;
        i_in_valid <= 1'b0;

        // drain and settle
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d directed): accept %0d, too old %0d,",
                 board.requests, directed_count,
                 board.verdict_count[VERDICT_ACCEPT], board.verdict_count[VERDICT_TOO_OLD]);
        $display("  duplicate %0d, auth fail %0d; checked %0d verdicts, %0d mismatches, %0d unexpected, %0d outstanding",
                 board.verdict_count[VERDICT_DUPLICATE], board.verdict_count[VERDICT_AUTH_FAIL],
                 board.checked, board.mismatches, board.unexpected, board.pending());
        if (!board.failed()) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
